// ===== sv/soundex_encoder_top_defines.svh =====
// Assertion macros shared by the soundex encoder modules.
`ifndef SOUNDEX_ENCODER_TOP_DEFINES_SVH
`define SOUNDEX_ENCODER_TOP_DEFINES_SVH
`ifndef SYNTH
`define SDX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("soundex encoder check failed");
`define SDX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("soundex encoder check failed");
`else
`define SDX_ASSERT_NOW(label, ante, cons)
`define SDX_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/sdx_pkg.sv =====
// Shared types, constants and the letter classifier of the soundex encoder.
package sdx_pkg;

  localparam logic [7:0] SYM_ZERO = 8'd48;
  localparam logic [2:0] CODE_LEN = 3'd4;

  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
    logic       last;
  } req_t;

  typedef struct packed {
    logic [7:0] first_letter;
    logic [5:0] digit_one;
    logic [5:0] digit_two;
    logic [5:0] digit_three;
  } code_t;

  typedef struct packed {
    logic       drop;
    logic [5:0] digit;
  } class_t;

  function automatic class_t classify(input logic [7:0] c);
    class_t r;
    r.drop  = 1'b0;
    r.digit = SYM_ZERO[5:0];
    case (c)
      "a", "e", "h", "i", "o", "u", "w", "y": r.drop = 1'b1;
      "b", "f", "p", "v": r.digit = SYM_ZERO[5:0] + 6'd1;
      "c", "g", "j", "k", "q", "s", "x", "z": r.digit = SYM_ZERO[5:0] + 6'd2;
      "d", "t": r.digit = SYM_ZERO[5:0] + 6'd3;
      "l": r.digit = SYM_ZERO[5:0] + 6'd4;
      "m", "n": r.digit = SYM_ZERO[5:0] + 6'd5;
      "r": r.digit = SYM_ZERO[5:0] + 6'd6;
      default: r.digit = SYM_ZERO[5:0];
    endcase
    return r;
  endfunction

endpackage

// ===== sv/sdx_in_stage.sv =====
// Input register of the soundex encoder: holds one character request.
module sdx_in_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       ch,
  input  logic             last,
  input  logic             advance,
  output sdx_pkg::req_t    req
);
  import sdx_pkg::*;

  logic       valid;
  logic [7:0] ch_q;
  logic       last_q;

  assign in_ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ch_q   <= ch;
      last_q <= last;
    end
  end

  assign req.valid = valid;
  assign req.ch    = ch_q;
  assign req.last  = last_q;

endmodule

// ===== sv/sdx_code.sv =====
// Code state of the soundex encoder: first letter, three digits and fill count.
`include "soundex_encoder_top_defines.svh"
module sdx_code (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  sdx_pkg::req_t   req,
  output sdx_pkg::code_t  code_next
);
  import sdx_pkg::*;

  logic [7:0] first_sym;
  logic [5:0] d1;
  logic [5:0] d2;
  logic [5:0] d3;
  logic [2:0] fill;
  logic       awaiting;

  logic [7:0] first_sym_next;
  logic [5:0] d1_next;
  logic [5:0] d2_next;
  logic [5:0] d3_next;
  logic [2:0] fill_next;
  class_t     cls;
  logic [7:0] last_sym;
  logic       append;

  always_comb begin
    cls = classify(req.ch);
    case (fill[1:0])
      2'd2:    last_sym = {2'b00, d1};
      2'd3:    last_sym = {2'b00, d2};
      default: last_sym = first_sym;
    endcase
    append = !awaiting && (fill < CODE_LEN) && !cls.drop &&
             ({2'b00, cls.digit} != last_sym);

    first_sym_next = awaiting ? req.ch : first_sym;
    d1_next        = d1;
    d2_next        = d2;
    d3_next        = d3;
    fill_next      = fill;
    if (append) begin
      fill_next = fill + 3'd1;
      case (fill[1:0])
        2'd1:    d1_next = cls.digit;
        2'd2:    d2_next = cls.digit;
        2'd3:    d3_next = cls.digit;
        default: d1_next = d1;
      endcase
    end

    code_next.first_letter = first_sym_next;
    code_next.digit_one    = d1_next;
    code_next.digit_two    = d2_next;
    code_next.digit_three  = d3_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && req.last)) begin
      first_sym <= SYM_ZERO;
      d1        <= SYM_ZERO[5:0];
      d2        <= SYM_ZERO[5:0];
      d3        <= SYM_ZERO[5:0];
      fill      <= 3'd1;
      awaiting  <= 1'b1;
    end else if (step) begin
      first_sym <= first_sym_next;
      d1        <= d1_next;
      d2        <= d2_next;
      d3        <= d3_next;
      fill      <= fill_next;
      awaiting  <= 1'b0;
    end
  end

  `SDX_ASSERT_NOW(a_fill_range, 1'b1, (fill >= 3'd1) && (fill <= CODE_LEN))
  `SDX_ASSERT_NOW(a_open_empty, awaiting, fill == 3'd1)
  `SDX_ASSERT_NEXT(a_word_end_clears, step && req.last, awaiting && (fill == 3'd1))
  `SDX_ASSERT_NEXT(a_first_taken, step && awaiting && !req.last, !awaiting)

endmodule

// ===== sv/sdx_out_stage.sv =====
// Result register of the soundex encoder: holds one finished code.
module sdx_out_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  sdx_pkg::code_t  code_in,
  output logic            can_load,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      first_letter,
  output logic [5:0]      digit_one,
  output logic [5:0]      digit_two,
  output logic [5:0]      digit_three
);
  import sdx_pkg::*;

  code_t code_q;

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      code_q <= code_in;
    end
  end

  assign first_letter = code_q.first_letter;
  assign digit_one    = code_q.digit_one;
  assign digit_two    = code_q.digit_two;
  assign digit_three  = code_q.digit_three;

endmodule

// ===== sv/soundex_encoder_top.sv =====
// Soundex encoder: one character per request in, one four-symbol code per word out.
//
// Input channel: in_valid/in_ready carry ch (8-bit character) and last, which
// marks the final character of a word. Output channel: out_valid/out_ready
// carry first_letter and the three ASCII digits digit_one..digit_three.
// The first character of a word is kept as is; later characters are mapped to
// Soundex digits, vowels and h, w, y dropped, repeats collapsed, up to three
// digits. Unfilled positions read '0'.
// Throughput: one character per cycle, unless a word's last character is held
// in the input register while the result register is blocked. The last
// character of a word passes through the input register; its code is then
// loaded into the result register, which raises out_valid.
// Characters without last produce no output.
// Reset (rst, synchronous) empties both registers and starts a new word.
// When the receiver stalls, the code holds in the result register; characters
// keep flowing until the next word's last character reaches the input register,
// which then holds and drops in_ready until the result is taken.
`include "soundex_encoder_top_defines.svh"
module soundex_encoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] first_letter,
  output logic [5:0] digit_one,
  output logic [5:0] digit_two,
  output logic [5:0] digit_three
);
  import sdx_pkg::*;

  req_t  req;
  code_t code_next;
  logic  can_load;
  logic  advance;

  // Advance the held character unless it closes a word and the result is blocked.
  assign advance = req.valid && (!req.last || can_load);

  sdx_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .ch       (ch),
    .last     (last),
    .advance  (advance),
    .req      (req)
  );

  sdx_code u_code (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .req       (req),
    .code_next (code_next)
  );

  sdx_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (advance && req.last),
    .code_in      (code_next),
    .can_load     (can_load),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .first_letter (first_letter),
    .digit_one    (digit_one),
    .digit_two    (digit_two),
    .digit_three  (digit_three)
  );

  `SDX_ASSERT_NOW(a_stall_cause, !in_ready, out_valid && !out_ready && req.last)
  `SDX_ASSERT_NEXT(a_word_to_out, advance && req.last, out_valid)

endmodule
